>>> src/trq_pkg.sv
`default_nettype none

package trq_pkg;

   // Field widths; the thread and queue counts fill the id spaces exactly
   localparam int THREAD_W    = 4;
   localparam int QUEUE_W     = 2;
   localparam int NUM_THREADS = 1 << THREAD_W;
   localparam int NUM_QUEUES  = 1 << QUEUE_W;
   // Walk step counter, wide enough to hold NUM_THREADS itself
   localparam int STEP_W      = THREAD_W + 1;

   // Request codes
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_HEAD   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_EMPTY  = 2'd1;
   localparam logic [1:0] ERR_QUEUED = 2'd2;
   localparam logic [1:0] ERR_ABSENT = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [THREAD_W-1:0] thread_id;
      logic [QUEUE_W-1:0]  queue_id;
   } trq_req_type;

   typedef struct packed {
      logic [THREAD_W-1:0] head_thread;
      logic                queue_empty;
      logic [1:0]          error_code;
   } trq_rsp_type;

   // Write port of the link memory
   typedef struct packed {
      logic                en;
      logic [THREAD_W-1:0] addr;
      logic [THREAD_W-1:0] data;
   } trq_link_wr_type;

endpackage

`default_nettype wire

>>> src/thread_ready_queue_core.sv
`default_nettype none

// Channel   Ports                          Payload
// request   req_valid / req_ready          req_data  (trq_req_type)
// response  rsp_valid / rsp_ready          rsp_data  (trq_rsp_type)
//
// One request at a time. An accepted request is first decoded; a rejected or
// unused request, or an append to an empty queue, finishes there. An append
// behind a tail reads the old tail's link, then writes the new thread's link
// and the old tail's link. Remove head reads the head through the tail's link
// and, unless it was the last thread, sets the tail's link past it; remove
// named thread walks links from the tail and unlinks it unless it is alone.
// Synchronous reset empties every queue; link, tail and member stores are not
// cleared. A finished response waits in the output register while the next
// request is taken; a second finished response holds the sequencer in idle,
// with req_ready low, until the output register drains.
module thread_ready_queue_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  trq_pkg::trq_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output trq_pkg::trq_rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_APP_LINK,
      S_APP_TAIL,
      S_HEAD_RD,
      S_HEAD_LINK,
      S_WALK,
      S_UNLINK
   } state_type;

   localparam int TW = trq_pkg::THREAD_W;
   localparam int QW = trq_pkg::QUEUE_W;
   localparam int NT = trq_pkg::NUM_THREADS;
   localparam int NQ = trq_pkg::NUM_QUEUES;
   localparam int SW = trq_pkg::STEP_W;

   // Sequencer state and scratch
   state_type            state_ff, state_in;
   logic                 done_ff, done_in;
   trq_pkg::trq_req_type req_ff, req_in;
   logic [TW-1:0]        p_ff, p_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           err_ff, err_in;
   logic [TW-1:0]        head_ff, head_in;

   // Queue bookkeeping
   logic [NT-1:0]        queued_ff, queued_in;
   logic [NQ-1:0]        nonempty_ff, nonempty_in;
   logic [QW-1:0]        member_ff [NT];
   logic [QW-1:0]        member_in [NT];
   logic [TW-1:0]        tail_ff [NQ];
   logic [TW-1:0]        tail_in [NQ];

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   trq_pkg::trq_rsp_type rsp_ff, rsp_in;

   // Link memory port
   trq_pkg::trq_link_wr_type link_wr;
   logic [TW-1:0]            rd_addr;
   logic [TW-1:0]            rd_data;

   logic [TW-1:0] t;
   logic [QW-1:0] q;
   logic [TW-1:0] tl;

   trq_link_mem u_link_mem (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign t  = req_ff.thread_id;
   assign q  = req_ff.queue_id;
   assign tl = tail_ff[q];

   assign req_ready = (state_ff == S_IDLE) && !done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: next state, bookkeeping updates and memory port
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      req_in       = req_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      head_in      = head_ff;
      queued_in    = queued_ff;
      nonempty_in  = nonempty_ff;
      member_in    = member_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      link_wr      = '0;
      rd_addr      = p_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               // publish once the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.head_thread = head_ff;
                  rsp_in.queue_empty = !nonempty_ff[q];
                  rsp_in.error_code  = err_ff;
                  done_in            = 1'b0;
               end
            end else if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            err_in   = trq_pkg::ERR_OK;
            head_in  = '0;
            p_in     = tl;
            cnt_in   = '0;
            state_in = S_IDLE;
            done_in  = 1'b1;
            unique case (req_ff.req_type)
               trq_pkg::REQ_APPEND: begin
                  if (queued_ff[t]) begin
                     err_in = trq_pkg::ERR_QUEUED;
                  end else begin
                     queued_in[t] = 1'b1;
                     member_in[t] = q;
                     tail_in[q]   = t;
                     nonempty_in[q] = 1'b1;
                     if (nonempty_ff[q]) begin
                        // splice after old tail: need its link first
                        rd_addr  = tl;
                        state_in = S_APP_LINK;
                        done_in  = 1'b0;
                     end else begin
                        link_wr = '{en: 1'b1, addr: t, data: t};
                     end
                  end
               end
               trq_pkg::REQ_HEAD: begin
                  if (!nonempty_ff[q]) begin
                     err_in = trq_pkg::ERR_EMPTY;
                  end else begin
                     rd_addr  = tl;
                     state_in = S_HEAD_RD;
                     done_in  = 1'b0;
                  end
               end
               trq_pkg::REQ_REMOVE: begin
                  if (!queued_ff[t] || member_ff[t] != q || !nonempty_ff[q]) begin
                     err_in = trq_pkg::ERR_ABSENT;
                  end else begin
                     rd_addr  = tl;
                     state_in = S_WALK;
                     done_in  = 1'b0;
                  end
               end
               default: begin
                  // unused code: no change
               end
            endcase
         end

         // new thread takes over the old tail's link
         S_APP_LINK: begin
            link_wr  = '{en: 1'b1, addr: t, data: rd_data};
            state_in = S_APP_TAIL;
         end

         // old tail now points at the new thread
         S_APP_TAIL: begin
            link_wr  = '{en: 1'b1, addr: p_ff, data: t};
            state_in = S_IDLE;
            done_in  = 1'b1;
         end

         // rd_data is the head
         S_HEAD_RD: begin
            head_in            = rd_data;
            queued_in[rd_data] = 1'b0;
            if (rd_data == tl) begin
               nonempty_in[q] = 1'b0;
               state_in       = S_IDLE;
               done_in        = 1'b1;
            end else begin
               rd_addr  = rd_data;
               state_in = S_HEAD_LINK;
            end
         end

         S_HEAD_LINK: begin
            link_wr  = '{en: 1'b1, addr: tl, data: rd_data};
            state_in = S_IDLE;
            done_in  = 1'b1;
         end

         // one link per cycle: compare next_link[p] against the target
         S_WALK: begin
            if (rd_data == t) begin
               queued_in[t] = 1'b0;
               if (p_ff == t) begin
                  nonempty_in[q] = 1'b0;
                  state_in       = S_IDLE;
                  done_in        = 1'b1;
               end else begin
                  rd_addr  = t;
                  state_in = S_UNLINK;
               end
            end else if (cnt_ff == SW'(NT)) begin
               err_in   = trq_pkg::ERR_ABSENT;
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               p_in    = rd_data;
               rd_addr = rd_data;
               cnt_in  = cnt_ff + SW'(1);
            end
         end

         // predecessor skips the removed thread
         S_UNLINK: begin
            link_wr = '{en: 1'b1, addr: p_ff, data: rd_data};
            if (tl == t) begin
               tail_in[q] = p_ff;
            end
            state_in = S_IDLE;
            done_in  = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, bookkeeping and output registers; payload needs no reset
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      p_ff      <= p_in;
      cnt_ff    <= cnt_in;
      err_ff    <= err_in;
      head_ff   <= head_in;
      member_ff <= member_in;
      tail_ff   <= tail_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         queued_ff    <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         queued_ff    <= queued_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/trq_link_mem.sv
`default_nettype none

// Next-link store: one write port, one read port with registered data
module trq_link_mem (
   input  wire                                  clock,
   input  trq_pkg::trq_link_wr_type             wr,
   input  wire  [trq_pkg::THREAD_W-1:0]         rd_addr,
   output logic [trq_pkg::THREAD_W-1:0]         rd_data
);

   logic [trq_pkg::THREAD_W-1:0] mem_ff [trq_pkg::NUM_THREADS];
   logic [trq_pkg::THREAD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sim/trq_response_check.sv
`default_nettype none

module trq_response_check (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  trq_pkg::trq_req_type  req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  trq_pkg::trq_rsp_type  rsp_data,
   output int                    mismatch_count,
   output int                    outstanding
);
   import trq_pkg::*;

   // Shadow of the queue state
   logic [THREAD_W-1:0] link_of  [NUM_THREADS];
   logic                in_queue [NUM_THREADS];
   logic [QUEUE_W-1:0]  owner_of [NUM_THREADS];
   logic [THREAD_W-1:0] tail_of  [NUM_QUEUES];
   logic                occupied [NUM_QUEUES];

   // Responses still owed by the block, oldest first
   trq_rsp_type awaited_rsp [$];
   trq_rsp_type oldest_rsp;

   // Apply one request to the shadow lists and return the response it earns
   function automatic trq_rsp_type apply_request(input trq_req_type r);
      trq_rsp_type         o;
      logic [THREAD_W-1:0] t;
      logic [QUEUE_W-1:0]  q;
      logic [THREAD_W-1:0] p;
      logic [THREAD_W-1:0] h;
      int                  steps;
      o = '0;
      o.error_code = ERR_OK;
      t = r.thread_id;
      q = r.queue_id;
      case (r.req_type)
         REQ_APPEND: begin
            if (in_queue[t]) begin
               o.error_code = ERR_QUEUED;
            end else begin
               // splice in after the tail; a lone thread links to itself
               if (occupied[q]) begin
                  p = tail_of[q];
                  link_of[t] = link_of[p];
                  link_of[p] = t;
               end else begin
                  link_of[t] = t;
               end
               tail_of[q]  = t;
               occupied[q] = 1'b1;
               in_queue[t] = 1'b1;
               owner_of[t] = q;
            end
         end
         REQ_HEAD: begin
            if (!occupied[q]) begin
               o.error_code = ERR_EMPTY;
            end else begin
               p = tail_of[q];
               h = link_of[p];
               if (h == p) occupied[q] = 1'b0;
               else        link_of[p] = link_of[h];
               in_queue[h]   = 1'b0;
               o.head_thread = h;
            end
         end
         REQ_REMOVE: begin
            if (!in_queue[t] || owner_of[t] != q || !occupied[q]) begin
               o.error_code = ERR_ABSENT;
            end else begin
               // find the predecessor of t around the ring
               p = tail_of[q];
               steps = 0;
               while (steps < NUM_THREADS && link_of[p] != t) begin
                  p = link_of[p];
                  steps++;
               end
               if (link_of[p] != t) begin
                  o.error_code = ERR_ABSENT;
               end else begin
                  if (p == t) begin
                     occupied[q] = 1'b0;
                  end else begin
                     link_of[p] = link_of[t];
                     if (tail_of[q] == t) tail_of[q] = p;
                  end
                  in_queue[t] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      o.queue_empty = !occupied[q];
      return o;
   endfunction

   // Watch both channels; predict on each request, compare on each response
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            link_of[i]  = '0;
            in_queue[i] = 1'b0;
            owner_of[i] = '0;
         end
         for (int i = 0; i < NUM_QUEUES; i++) begin
            tail_of[i]  = '0;
            occupied[i] = 1'b0;
         end
         awaited_rsp.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) awaited_rsp.push_back(apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response: head %0d empty %0d error %0d", $time,
                        rsp_data.head_thread, rsp_data.queue_empty, rsp_data.error_code);
               mismatch_count++;
            end else begin
               oldest_rsp = awaited_rsp.pop_front();
               if (rsp_data.head_thread !== oldest_rsp.head_thread) begin
                  $display("%0t: head_thread expected %0d got %0d", $time,
                           oldest_rsp.head_thread, rsp_data.head_thread);
                  mismatch_count++;
               end
               if (rsp_data.queue_empty !== oldest_rsp.queue_empty) begin
                  $display("%0t: queue_empty expected %0d got %0d", $time,
                           oldest_rsp.queue_empty, rsp_data.queue_empty);
                  mismatch_count++;
               end
               if (rsp_data.error_code !== oldest_rsp.error_code) begin
                  $display("%0t: error_code expected %0d got %0d", $time,
                           oldest_rsp.error_code, rsp_data.error_code);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = awaited_rsp.size();
   end

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   import trq_pkg::*;

   // The request code the block leaves unused
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   trq_req_type req_data  = '0;
   trq_rsp_type rsp_data;
   int          mismatch_count;
   int          outstanding;

   // No idling on either side while set
   logic calm = 1'b0;

   // Stimulus-side view of queue membership, used to aim requests
   int where_is  [NUM_THREADS];
   int joined_at [NUM_THREADS];
   int join_seq = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   thread_ready_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   trq_response_check rsp_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Issue one request, wait for it to be taken, then maybe go idle
   task automatic send_req(input logic [1:0] kind, input logic [3:0] tid,
                           input logic [1:0] qid);
      int first;
      first = -1;
      // track membership so later requests can hit queued threads
      case (kind)
         REQ_APPEND: begin
            if (where_is[tid] < 0) begin
               where_is[tid]  = int'(qid);
               joined_at[tid] = join_seq++;
            end
         end
         REQ_HEAD: begin
            for (int i = 0; i < NUM_THREADS; i++)
               if (where_is[i] == int'(qid) &&
                   (first < 0 || joined_at[i] < joined_at[first]))
                  first = i;
            if (first >= 0) where_is[first] = -1;
         end
         REQ_REMOVE: begin
            if (where_is[tid] == int'(qid)) where_is[tid] = -1;
         end
         default: ;
      endcase
      req_data  <= {kind, tid, qid};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Response side: ready most of the time, with stall bursts
   initial begin
      wait (!reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
         if (!calm && $urandom_range(0, 1) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      int         done_items;
      int         pick;
      int         n_cand;
      int         cand [NUM_THREADS];
      logic       filling;
      logic [1:0] kind;
      logic [3:0] t;
      logic [1:0] q;
      done_items = 0;
      for (int i = 0; i < NUM_THREADS; i++) where_is[i] = -1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: errors, unused code, and every position of removal
      send_req(REQ_HEAD,   4'd0,  2'd0);   // head of empty queue
      send_req(REQ_REMOVE, 4'd5,  2'd0);   // thread not queued
      send_req(REQ_UNUSED, 4'd9,  2'd1);
      send_req(REQ_APPEND, 4'd0,  2'd0);
      send_req(REQ_APPEND, 4'd15, 2'd0);
      send_req(REQ_APPEND, 4'd15, 2'd3);   // already in another queue
      send_req(REQ_APPEND, 4'd0,  2'd0);   // already in this queue
      send_req(REQ_REMOVE, 4'd15, 2'd1);   // queued elsewhere
      send_req(REQ_APPEND, 4'd7,  2'd0);
      send_req(REQ_REMOVE, 4'd7,  2'd0);   // tail moves back
      send_req(REQ_REMOVE, 4'd0,  2'd0);   // head by name
      send_req(REQ_REMOVE, 4'd15, 2'd0);   // only element
      send_req(REQ_APPEND, 4'd3,  2'd3);
      send_req(REQ_APPEND, 4'd9,  2'd3);
      send_req(REQ_APPEND, 4'd12, 2'd3);
      send_req(REQ_REMOVE, 4'd9,  2'd3);   // middle
      send_req(REQ_HEAD,   4'd0,  2'd3);
      send_req(REQ_HEAD,   4'd0,  2'd3);   // last one out
      send_req(REQ_HEAD,   4'd0,  2'd3);
      send_req(REQ_APPEND, 4'd10, 2'd2);
      send_req(REQ_UNUSED, 4'd6,  2'd2);   // reports a non-empty queue
      send_req(REQ_HEAD,   4'd15, 2'd2);

      // random: alternate fill and drain phases, mostly well-aimed requests
      while (done_items < 1850) begin
         calm    = (done_items >= 700 && done_items < 850) || done_items >= 1600;
         filling = ((done_items / 150) % 2) == 0;
         pick    = $urandom_range(0, 99);
         t       = 4'($urandom_range(0, 15));
         q       = 2'($urandom_range(0, 3));
         n_cand  = 0;
         if (pick < 5) begin
            kind = REQ_UNUSED;
         end else if (pick < (filling ? 55 : 30)) begin
            kind = REQ_APPEND;
            if ($urandom_range(0, 4) != 0) begin
               for (int i = 0; i < NUM_THREADS; i++)
                  if (where_is[i] < 0) cand[n_cand++] = i;
               if (n_cand > 0) t = 4'(cand[$urandom_range(0, n_cand - 1)]);
            end
         end else if (pick < (filling ? 72 : 62)) begin
            kind = REQ_HEAD;
         end else begin
            kind = REQ_REMOVE;
            if ($urandom_range(0, 4) != 0) begin
               for (int i = 0; i < NUM_THREADS; i++)
                  if (where_is[i] >= 0) cand[n_cand++] = i;
               if (n_cand > 0) begin
                  t = 4'(cand[$urandom_range(0, n_cand - 1)]);
                  q = 2'(where_is[t]);
               end
            end
         end
         send_req(kind, t, q);
         if (kind != REQ_UNUSED) done_items++;
      end
      req_valid <= 1'b0;

      // drain, then give the block time to show any stray response
      wait (outstanding == 0);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hang guard
   initial begin
      #8000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
